/* design/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache
// Holds the controller state type, operation codes and register constants.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

/* design/lkvc_ram.sv */
// ----------------------------------------------------------------------------
// lkvc_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lru_key_value_cache_core.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: key-value cache with least-recently-used eviction
// Keys, values and recency ranks sit in three RAMs that are swept slot by slot.
// ----------------------------------------------------------------------------
// Each accepted item passes through S_SEARCH, S_DECIDE, S_UPDATE and S_DONE
// in order; a get miss skips S_UPDATE. A new item is accepted only in S_IDLE,
// so items do not overlap. The search and rank update sweeps visit one slot
// a cycle.
// Reset (synchronous, active low) clears all valid bits, the occupancy count
// and the controller; capacity returns to 16. No RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lkvc_pkg::CAP_BITS-1:0] i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic [VALUE_BITS-1:0]         o_read_value,
    output logic                          o_evicted,
    output logic [KEY_BITS-1:0]           o_evicted_key
);

    import lkvc_pkg::*;

    localparam int IDXW = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int EW   = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam logic [CW-1:0] CNT_END = CW'(ENTRIES);
    localparam logic [EW-1:0] CAP_MAX = EW'(ENTRIES);

    t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_pend, n_pend;
    logic [IDXW-1:0] r_pidx, n_pidx;

    logic                  r_act, n_act;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;

    logic [CAP_BITS-1:0] r_cap, n_cap;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [CW-1:0]       r_occ, n_occ;

    // Search results.
    logic                  r_found, n_found;
    logic [IDXW-1:0]       r_fslot, n_fslot;
    logic [IDXW-1:0]       r_frank, n_frank;
    logic [VALUE_BITS-1:0] r_fvalue, n_fvalue;
    logic                  r_old_any, n_old_any;
    logic [IDXW-1:0]       r_oslot, n_oslot;
    logic [IDXW-1:0]       r_orank, n_orank;
    logic [KEY_BITS-1:0]   r_okey, n_okey;
    logic                  r_free_any, n_free_any;
    logic [IDXW-1:0]       r_free_slot, n_free_slot;

    // Rank update control.
    logic [IDXW-1:0] r_slot, n_slot;
    logic [IDXW-1:0] r_lim, n_lim;
    logic            r_ins, n_ins;

    // Pending result and output register.
    logic                  r_res_hit, n_res_hit;
    logic [VALUE_BITS-1:0] r_res_rv, n_res_rv;
    logic                  r_res_ev, n_res_ev;
    logic [KEY_BITS-1:0]   r_res_ek, n_res_ek;
    logic                  r_out_valid, n_out_valid;
    logic                  r_o_hit, n_o_hit;
    logic [VALUE_BITS-1:0] r_o_rv, n_o_rv;
    logic                  r_o_ev, n_o_ev;
    logic [KEY_BITS-1:0]   r_o_ek, n_o_ek;

    // RAM ports.
    logic [IDXW-1:0]       rd_addr;
    logic [KEY_BITS-1:0]   key_rdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic [IDXW-1:0]       rank_rdata;
    logic                  key_we, val_we, rank_we;
    logic [IDXW-1:0]       kv_waddr;
    logic [IDXW-1:0]       rank_wdata;

    assign rd_addr = r_cnt[IDXW-1:0];

    lkvc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (kv_waddr),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    lkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (kv_waddr),
        .i_wdata (r_value),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    lkvc_ram #(.WIDTH(IDXW), .DEPTH(ENTRIES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (r_pidx),
        .i_wdata (rank_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rank_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_cap       <= CAP_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_cap       <= n_cap;
            r_valid     <= n_valid;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx      <= n_pidx;
        r_act       <= n_act;
        r_key       <= n_key;
        r_value     <= n_value;
        r_found     <= n_found;
        r_fslot     <= n_fslot;
        r_frank     <= n_frank;
        r_fvalue    <= n_fvalue;
        r_old_any   <= n_old_any;
        r_oslot     <= n_oslot;
        r_orank     <= n_orank;
        r_okey      <= n_okey;
        r_free_any  <= n_free_any;
        r_free_slot <= n_free_slot;
        r_slot      <= n_slot;
        r_lim       <= n_lim;
        r_ins       <= n_ins;
        r_res_hit   <= n_res_hit;
        r_res_rv    <= n_res_rv;
        r_res_ev    <= n_res_ev;
        r_res_ek    <= n_res_ek;
        r_o_hit     <= n_o_hit;
        r_o_rv      <= n_o_rv;
        r_o_ev      <= n_o_ev;
        r_o_ek      <= n_o_ek;
    end

    always_comb begin
        logic          pv;
        logic [EW-1:0] cap_eff;
        logic          use_old;

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_act       = r_act;
        n_key       = r_key;
        n_value     = r_value;
        n_cap       = r_cap;
        n_valid     = r_valid;
        n_occ       = r_occ;
        n_found     = r_found;
        n_fslot     = r_fslot;
        n_frank     = r_frank;
        n_fvalue    = r_fvalue;
        n_old_any   = r_old_any;
        n_oslot     = r_oslot;
        n_orank     = r_orank;
        n_okey      = r_okey;
        n_free_any  = r_free_any;
        n_free_slot = r_free_slot;
        n_slot      = r_slot;
        n_lim       = r_lim;
        n_ins       = r_ins;
        n_res_hit   = r_res_hit;
        n_res_rv    = r_res_rv;
        n_res_ev    = r_res_ev;
        n_res_ek    = r_res_ek;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_hit     = r_o_hit;
        n_o_rv      = r_o_rv;
        n_o_ev      = r_o_ev;
        n_o_ek      = r_o_ek;
        key_we      = 1'b0;
        val_we      = 1'b0;
        rank_we     = 1'b0;
        kv_waddr    = r_fslot;
        rank_wdata  = rank_rdata;
        o_in_ready  = 1'b0;

        pv = r_valid[r_pidx];

        cap_eff = EW'(r_cap);
        if (cap_eff == '0) begin
            cap_eff = EW'(1);
        end else if (cap_eff > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end
        use_old = (EW'(r_occ) >= cap_eff) || !r_free_any;

        if (i_cfg_wr_en) begin
            n_cap = i_cfg_wr_data;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_act      = i_action;
                    n_key      = i_key;
                    n_value    = i_value;
                    n_cnt      = '0;
                    n_found    = 1'b0;
                    n_old_any  = 1'b0;
                    n_free_any = 1'b0;
                    n_state    = S_SEARCH;
                end
            end

            S_SEARCH: begin
                if (r_cnt != CNT_END) begin
                    n_cnt  = r_cnt + CW'(1);
                    n_pend = 1'b1;
                    n_pidx = rd_addr;
                end else begin
                    n_state = S_DECIDE;
                end
                // Evaluate the slot read in the previous cycle.
                if (r_pend) begin
                    if (pv && key_rdata == r_key && !r_found) begin
                        n_found  = 1'b1;
                        n_fslot  = r_pidx;
                        n_frank  = rank_rdata;
                        n_fvalue = val_rdata;
                    end
                    if (pv && (!r_old_any || rank_rdata > r_orank)) begin
                        n_old_any = 1'b1;
                        n_oslot   = r_pidx;
                        n_orank   = rank_rdata;
                        n_okey    = key_rdata;
                    end
                    if (!pv && !r_free_any) begin
                        n_free_any  = 1'b1;
                        n_free_slot = r_pidx;
                    end
                end
            end

            S_DECIDE: begin
                n_res_hit = 1'b0;
                n_res_rv  = '0;
                n_res_ev  = 1'b0;
                n_res_ek  = '0;
                n_cnt     = '0;
                n_ins     = 1'b0;
                n_slot    = r_fslot;
                n_lim     = r_frank;
                n_state   = S_UPDATE;
                if (r_act == ACT_GET) begin
                    if (r_found) begin
                        n_res_hit = 1'b1;
                        n_res_rv  = r_fvalue;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_found) begin
                    n_res_hit = 1'b1;
                    val_we    = 1'b1;
                    kv_waddr  = r_fslot;
                end else if (use_old) begin
                    // Full: the oldest slot is evicted and reused.
                    n_res_ev = 1'b1;
                    n_res_ek = r_okey;
                    n_slot   = r_oslot;
                    n_lim    = r_orank;
                    key_we   = 1'b1;
                    val_we   = 1'b1;
                    kv_waddr = r_oslot;
                end else begin
                    // Insert into a free slot: every valid entry ages by one.
                    n_slot   = r_free_slot;
                    n_ins    = 1'b1;
                    n_valid[r_free_slot] = 1'b1;
                    n_occ    = r_occ + CW'(1);
                    key_we   = 1'b1;
                    val_we   = 1'b1;
                    kv_waddr = r_free_slot;
                end
            end

            S_UPDATE: begin
                if (r_cnt != CNT_END) begin
                    n_cnt  = r_cnt + CW'(1);
                    n_pend = 1'b1;
                    n_pidx = rd_addr;
                end else begin
                    n_state = S_DONE;
                end
                // Write back the rank read in the previous cycle.
                if (r_pend) begin
                    rank_we = 1'b1;
                    if (r_pidx == r_slot) begin
                        rank_wdata = '0;
                    end else if (pv && (r_ins || rank_rdata < r_lim)) begin
                        rank_wdata = rank_rdata + IDXW'(1);
                    end else begin
                        rank_wdata = rank_rdata;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_hit     = r_res_hit;
                    n_o_rv      = r_res_rv;
                    n_o_ev      = r_res_ev;
                    n_o_ek      = r_res_ek;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_o_hit;
    assign o_read_value  = r_o_rv;
    assign o_evicted     = r_o_ev;
    assign o_evicted_key = r_o_ek;

endmodule
